[rtl/vctp_pkg.sv]
// Shared constants, types and tables for the vertical circle trajectory point block.
package vctp_pkg;

    // CORDIC depth; the angle table has 30 usable entries, deeper settings act as 30.
    localparam int CORDIC_STEPS      = 16;
    localparam int CORDIC_TABLE_LEN  = 30;
    localparam int NSTEPS            = (CORDIC_STEPS > CORDIC_TABLE_LEN) ?
                                       CORDIC_TABLE_LEN : CORDIC_STEPS;

    localparam logic [31:0] DURATION_LIMIT_MS = 32'd1000000;

    localparam int XY_W   = 33;   // CORDIC x/y, Q1.30 plus headroom for gain overshoot
    localparam int Z_W    = 32;   // residual angle, 2^-32 turn units
    localparam int STEP_W = 5;
    localparam int ADDR_W = 5;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // atan(2^-i) in 2^-32 turn units, rounded; padded to a full power of two
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CTR_X       = 3'd0;
    localparam logic [2:0] REG_CTR_Y       = 3'd1;
    localparam logic [2:0] REG_CTR_Z       = 3'd2;
    localparam logic [2:0] REG_RADIUS      = 3'd3;
    localparam logic [2:0] REG_START_PHASE = 3'd4;
    localparam logic [2:0] REG_PHASE_RATE  = 3'd5;
    localparam logic [2:0] REG_DURATION    = 3'd6;
    localparam logic [2:0] REG_START_TIME  = 3'd7;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic [31:0] ctr_x;
        logic [31:0] ctr_y;
        logic [31:0] ctr_z;
        logic [30:0] radius;
        logic [31:0] start_phase;
        logic [31:0] phase_rate;
        logic [31:0] duration_ms;
        logic [31:0] start_time_ms;
    } t_cfg;

    // word moving along the CORDIC chain
    typedef struct packed {
        logic                   vld;
        logic [1:0]             quad;
        logic                   done;
        logic                   pv;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cell;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        pose_valid;
        logic        done_res;
    } t_res;

endpackage

[rtl/vctp_if.sv]
// Valid/ready channel interfaces: time stamp input and setpoint output.
interface vctp_in_if ();
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;

    modport source (output valid, output time_ms, input ready);
    modport sink   (input valid, input time_ms, output ready);
endinterface

interface vctp_out_if ();
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        pose_valid;
    logic        done_res;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output pose_valid, output done_res, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input pose_valid, input done_res, output ready);
endinterface

[rtl/vctp_regs.sv]
// APB configuration register file.
module vctp_regs import vctp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_CTR_X:       r_cfg.ctr_x         <= pwdata;
                REG_CTR_Y:       r_cfg.ctr_y         <= pwdata;
                REG_CTR_Z:       r_cfg.ctr_z         <= pwdata;
                REG_RADIUS:      r_cfg.radius        <= pwdata[30:0];
                REG_START_PHASE: r_cfg.start_phase   <= pwdata;
                REG_PHASE_RATE:  r_cfg.phase_rate    <= pwdata;
                REG_DURATION:    r_cfg.duration_ms   <= pwdata;
                REG_START_TIME:  r_cfg.start_time_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CTR_X:       prdata = r_cfg.ctr_x;
            REG_CTR_Y:       prdata = r_cfg.ctr_y;
            REG_CTR_Z:       prdata = r_cfg.ctr_z;
            REG_RADIUS:      prdata = {1'b0, r_cfg.radius};
            REG_START_PHASE: prdata = r_cfg.start_phase;
            REG_PHASE_RATE:  prdata = r_cfg.phase_rate;
            REG_DURATION:    prdata = r_cfg.duration_ms;
            REG_START_TIME:  prdata = r_cfg.start_time_ms;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/vctp_cell.sv]
// One CORDIC rotation-mode micro-rotation, registered.
module vctp_cell import vctp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_step i_step,
    input  t_cell i_d,
    output t_cell o_q
);

    logic                   r_vld;
    t_cell                  r_pay;
    logic signed [XY_W-1:0] w_x;
    logic signed [XY_W-1:0] w_y;
    logic signed [Z_W-1:0]  w_z;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic signed [Z_W-1:0]  w_at;
    t_cell                  n_pay;

    assign w_x  = i_d.x;
    assign w_y  = i_d.y;
    assign w_z  = i_d.z;
    assign w_xs = w_x >>> i_step;   // floor shift
    assign w_ys = w_y >>> i_step;
    assign w_at = $signed(ATAN_TAB[i_step]);

    always_comb begin
        n_pay = i_d;
        if (!w_z[Z_W-1]) begin
            n_pay.x = w_x - w_ys;
            n_pay.y = w_y + w_xs;
            n_pay.z = w_z - w_at;
        end else begin
            n_pay.x = w_x + w_ys;
            n_pay.y = w_y - w_xs;
            n_pay.z = w_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay <= n_pay;
        end
    end

    always_comb begin
        o_q     = r_pay;
        o_q.vld = r_vld;
    end

endmodule

[rtl/vertical_circle_trajectory_point.sv]
// Top level: circle setpoint generator with pipelined CORDIC chain.
//
// Usage
//   Input channel i_in carries one word per time stamp (time_ms). Output channel
//   o_out returns one setpoint word per input word, in order: pos_x/y/z in
//   Q16.16 metres, pose_valid and done_res.
//   Registers are written over the APB port (8 registers at byte address 4*i); the user
//   must do so while no word is in flight, which the block does not enforce; pready is tied high.
// Pipeline and throughput
//   A word accepted on i_in passes, in order, the elapsed-time register (stage A,
//   loaded at the accepting edge), the phase multiply (stage B), the CORDIC
//   cells, the quadrant fold (P1), the radius multiply (P2) and the output
//   register.
//   One word per cycle is sustained while the skid is empty; the chain of CORDIC
//   cells holds one word per cell.
// Reset
//   i_rst_n (synchronous, low) empties the pipeline and clears the valid flags and the configuration registers.
// Backpressure
//   When o_out.ready is low with a word held, the next word lands in a skid
//   register; while the skid is full i_in.ready drops and the whole pipeline
//   freezes, so nothing is lost or repeated.
module vertical_circle_trajectory_point import vctp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vctp_in_if.sink           i_in,
    vctp_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > $signed(64'h0000_0000_7FFF_FFFF)) begin
            return 32'h7FFF_FFFF;
        end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    t_cfg w_cfg;

    vctp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // whole pipeline advances unless the skid holds a word
    logic r_skid_vld;
    logic w_en;
    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    // stage A: signed elapsed time and flags
    logic        r_a_vld;
    logic [31:0] r_a_diff;
    logic        r_a_done;
    logic        r_a_pv;
    logic [31:0] w_diff;

    assign w_diff = i_in.time_ms - w_cfg.start_time_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_diff <= w_diff;
            // negative elapsed time never reaches the duration
            r_a_done <= !w_diff[31] && (w_diff >= w_cfg.duration_ms);
            r_a_pv   <= (w_cfg.duration_ms != 32'd0) &&
                        (w_cfg.duration_ms < DURATION_LIMIT_MS);
        end
    end

    // stage B: phase = start + elapsed * rate, modulo one turn
    logic        r_b_vld;
    logic [31:0] r_b_phase;
    logic        r_b_done;
    logic        r_b_pv;
    logic [31:0] w_prod;

    assign w_prod = r_a_diff * w_cfg.phase_rate;   // low word only

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_phase <= w_cfg.start_phase + w_prod;
            r_b_done  <= r_a_done;
            r_b_pv    <= r_a_pv;
        end
    end

    // split the phase into a quadrant and a residual in [-1/8, 1/8) turn
    logic [31:0] w_ang;
    t_cell       w_head;
    t_cell       w_chain [NSTEPS+1];

    assign w_ang = r_b_phase + 32'h2000_0000;

    always_comb begin
        w_head.vld  = r_b_vld;
        w_head.quad = w_ang[31:30];
        w_head.done = r_b_done;
        w_head.pv   = r_b_pv;
        w_head.x    = CORDIC_GAIN_Q30;
        w_head.y    = '0;
        w_head.z    = $signed({2'b00, w_ang[29:0]}) - 32'sh2000_0000;
    end

    assign w_chain[0] = w_head;

    // CORDIC cell row
    for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
        vctp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_step  (STEP_W'(k)),
            .i_d     (w_chain[k]),
            .o_q     (w_chain[k+1])
        );
    end

    // stage P1: fold the quadrant back in
    t_cell                  w_end;
    logic signed [XY_W-1:0] n_sin;
    logic signed [XY_W-1:0] n_cos;
    logic                   r_p1_vld;
    logic signed [31:0]     r_p1_sin;
    logic signed [31:0]     r_p1_cos;
    logic                   r_p1_done;
    logic                   r_p1_pv;

    assign w_end = w_chain[NSTEPS];

    always_comb begin
        case (w_end.quad)
            QUAD_0: begin n_cos = w_end.x;  n_sin = w_end.y;  end
            QUAD_1: begin n_cos = -w_end.y; n_sin = w_end.x;  end
            QUAD_2: begin n_cos = -w_end.x; n_sin = -w_end.y; end
            QUAD_3: begin n_cos = w_end.y;  n_sin = -w_end.x; end
            default: begin n_cos = w_end.x; n_sin = w_end.y; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_end.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_sin  <= $signed(n_sin[31:0]);   // |value| stays near 2^30
            r_p1_cos  <= $signed(n_cos[31:0]);
            r_p1_done <= w_end.done;
            r_p1_pv   <= w_end.pv;
        end
    end

    // stage P2: radius products, Q16.16 x Q1.30
    logic                r_p2_vld;
    logic signed [63:0]  r_p2_my;
    logic signed [63:0]  r_p2_mz;
    logic                r_p2_done;
    logic                r_p2_pv;
    logic signed [31:0]  w_rad;

    assign w_rad = $signed({1'b0, w_cfg.radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_my   <= 64'(w_rad) * 64'(r_p1_sin);
            r_p2_mz   <= 64'(w_rad) * 64'(r_p1_cos);
            r_p2_done <= r_p1_done;
            r_p2_pv   <= r_p1_pv;
        end
    end

    // round to Q16.16, add center, saturate; all zero when the pose is not valid
    logic signed [63:0] w_dy;
    logic signed [63:0] w_dz;
    logic signed [63:0] w_sy;
    logic signed [63:0] w_sz;
    t_res               w_res;

    assign w_dy = (r_p2_my + 64'sd536870912) >>> 30;
    assign w_dz = (r_p2_mz + 64'sd536870912) >>> 30;
    assign w_sy = $signed({{32{w_cfg.ctr_y[31]}}, w_cfg.ctr_y}) + w_dy;
    assign w_sz = $signed({{32{w_cfg.ctr_z[31]}}, w_cfg.ctr_z}) + w_dz;

    always_comb begin
        w_res.pose_valid = r_p2_pv;
        w_res.done_res   = r_p2_done;
        if (r_p2_pv) begin
            w_res.pos_x = w_cfg.ctr_x;
            w_res.pos_y = sat32(w_sy);
            w_res.pos_z = sat32(w_sz);
        end else begin
            w_res.pos_x = '0;
            w_res.pos_y = '0;
            w_res.pos_z = '0;
        end
    end

    // output register plus skid
    logic r_out_vld;
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_p2_vld) begin
            if (r_out_vld && !o_out.ready) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (r_p2_vld) begin
            if (r_out_vld && !o_out.ready) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.pos_x      = r_out.pos_x;
    assign o_out.pos_y      = r_out.pos_y;
    assign o_out.pos_z      = r_out.pos_z;
    assign o_out.pose_valid = r_out.pose_valid;
    assign o_out.done_res   = r_out.done_res;

    // skid only ever holds a word behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid full with empty output register");

    // skid fills only when the output word was stalled
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !o_out.ready))
        else $error("skid filled without a stall");

    // a held skid word is not dropped while the receiver stalls
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !o_out.ready |=> r_skid_vld && $stable(r_skid))
        else $error("skid word lost during stall");

    // out-of-range duration yields a zero pose
    a_zero_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.pose_valid |->
            o_out.pos_x == 32'd0 && o_out.pos_y == 32'd0 && o_out.pos_z == 32'd0)
        else $error("nonzero position on invalid pose");

endmodule
